// ===== design/usr_pkg.sv =====
// shared widths, register codes, reset values and types for the sweep ranger
package usr_pkg;

   localparam int ANGLE_W     = 8;
   localparam int ASTEP_W     = 7;
   localparam int SPA_REG_W   = 4;
   localparam int DIST_W      = 17;
   localparam int WIDTH_W     = 16;
   localparam int DIST_MUL_W  = 13;
   localparam int DIST_SHIFT  = 10;
   localparam int PROD_W      = WIDTH_W + DIST_MUL_W;
   localparam int RAW_DIST_W  = PROD_W - DIST_SHIFT;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 17;

   localparam logic [DIST_MUL_W-1:0] DIST_MUL = 13'd4496;

   localparam logic [CSR_IDX_W-1:0] REG_MIN_ANGLE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ANGLE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_ANGLE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLES      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_DISTANCE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DISTANCE = 3'd5;

   localparam logic [ANGLE_W-1:0]   RST_MIN_ANGLE    = 8'd15;
   localparam logic [ANGLE_W-1:0]   RST_MAX_ANGLE    = 8'd165;
   localparam logic [ASTEP_W-1:0]   RST_STEP_ANGLE   = 7'd2;
   localparam logic [SPA_REG_W-1:0] RST_SAMPLES      = 4'd3;
   localparam logic [DIST_W-1:0]    RST_MIN_DISTANCE = 17'd512;
   localparam logic [DIST_W-1:0]    RST_MAX_DISTANCE = 17'd102400;

   localparam int USR_MAX_SAMPLES = 8;
   localparam int QUEUE_DEPTH     = 2;

   typedef struct packed {
      logic [ANGLE_W-1:0]   angle_lo;
      logic [ANGLE_W-1:0]   angle_hi;
      logic [ASTEP_W-1:0]   angle_inc;
      logic [SPA_REG_W-1:0] sample_count;
      logic [DIST_W-1:0]    min_distance_q8;
      logic [DIST_W-1:0]    max_distance_q8;
   } cfg_type;

   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] dist_q8;
   } reading_type;

endpackage

// ===== design/usr_front.sv =====
// front end: converts echo width to distance and classifies it against the window
module usr_front import usr_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [WIDTH_W-1:0] req_echo_width_us,
   output logic               q_push,
   output reading_type        q_data,
   input  logic               q_full
);

   logic                  s_valid_ff, s_valid_in;
   logic [RAW_DIST_W-1:0] s_dist_ff, s_dist_in;
   logic                  accept;
   logic [PROD_W-1:0]     prod;
   logic [RAW_DIST_W-1:0] min_x, max_x;

   assign req_stall = s_valid_ff & q_full;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      prod       = PROD_W'(req_echo_width_us) * PROD_W'(DIST_MUL);
      s_dist_in  = accept ? prod[PROD_W-1:DIST_SHIFT] : s_dist_ff;
      s_valid_in = accept | (s_valid_ff & q_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
      end
      s_dist_ff <= s_dist_in;
   end

   // zero distance only comes from a zero width, which is no echo
   always_comb begin
      min_x          = RAW_DIST_W'(cfg.min_distance_q8);
      max_x          = RAW_DIST_W'(cfg.max_distance_q8);
      q_push         = s_valid_ff & ~q_full;
      q_data.hit     = (s_dist_ff != '0) && (s_dist_ff >= min_x) && (s_dist_ff <= max_x);
      q_data.dist_q8 = s_dist_ff[DIST_W-1:0];
   end

endmodule

// ===== design/usr_queue.sv =====
// short fifo of classified readings between front and back
module usr_queue import usr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  reading_type push_data,
   output logic        full,
   input  logic        pop,
   output reading_type head,
   output logic        empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   reading_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/usr_back.sv =====
// back end: accumulates readings per angle, divides for the mean, steps the sweep
module usr_back import usr_pkg::*; #(
   parameter int MAX_SAMPLES = USR_MAX_SAMPLES
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               q_empty,
   input  reading_type        q_head,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ANGLE_W-1:0] rsp_scan_angle,
   output logic [DIST_W-1:0]  rsp_mean_distance_q8,
   output logic               rsp_found,
   output logic [ANGLE_W-1:0] rsp_next_angle
);

   localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W   = DIST_W + $clog2(MAX_SAMPLES);
   localparam int DSTEP_W = $clog2(SUM_W + 1);
   localparam int SPA_W   = (CNT_W > SPA_REG_W) ? CNT_W : SPA_REG_W;

   localparam logic [1:0] ST_TAKE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_SEND = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   taken_ff, taken_in;
   logic [CNT_W-1:0]   vcnt_ff, vcnt_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [ANGLE_W-1:0] sweep_ff, sweep_in;
   logic               down_ff, down_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   div_ff, div_in;
   logic [DSTEP_W-1:0] step_ff, step_in;
   logic               found_ff, found_in;
   logic [ANGLE_W-1:0] here_ff, here_in;
   logic [ANGLE_W-1:0] nxt_ff, nxt_in;

   logic [SPA_W-1:0]   spa_x, max_x, eff;
   logic [CNT_W-1:0]   taken_next, vcnt_next;
   logic [SUM_W-1:0]   sum_next;
   logic               last;
   logic [ANGLE_W:0]   up_sum, low_lim;
   logic               up_ok, dn_ok;
   logic [ANGLE_W-1:0] sweep_adv;
   logic               down_adv;
   logic [CNT_W:0]     trial, diff;
   logic               ge;

   assign q_pop                = (state_ff == ST_TAKE) && !q_empty;
   assign rsp_valid            = (state_ff == ST_SEND);
   assign rsp_scan_angle       = here_ff;
   assign rsp_mean_distance_q8 = quo_ff[DIST_W-1:0];
   assign rsp_found            = found_ff;
   assign rsp_next_angle       = nxt_ff;

   // effective sample count: zero acts as one, clipped to the storage limit
   always_comb begin
      spa_x = SPA_W'(cfg.sample_count);
      max_x = SPA_W'(MAX_SAMPLES);
      if (spa_x == '0) begin
         eff = SPA_W'(1);
      end else if (spa_x > max_x) begin
         eff = max_x;
      end else begin
         eff = spa_x;
      end
   end

   always_comb begin
      taken_next = taken_ff + 1'b1;
      vcnt_next  = vcnt_ff + CNT_W'(q_head.hit);
      sum_next   = sum_ff + (q_head.hit ? SUM_W'(q_head.dist_q8) : '0);
      last       = SPA_W'(taken_next) >= eff;
   end

   // sweep step; turning angles can repeat
   always_comb begin
      up_sum  = {1'b0, sweep_ff} + (ANGLE_W + 1)'(cfg.angle_inc);
      low_lim = {1'b0, cfg.angle_lo} + (ANGLE_W + 1)'(cfg.angle_inc);
      up_ok   = up_sum <= {1'b0, cfg.angle_hi};
      dn_ok   = {1'b0, sweep_ff} >= low_lim;
      if (!down_ff) begin
         sweep_adv = up_ok ? up_sum[ANGLE_W-1:0] : cfg.angle_hi;
         down_adv  = !up_ok;
      end else begin
         sweep_adv = dn_ok ? (sweep_ff - ANGLE_W'(cfg.angle_inc)) : cfg.angle_lo;
         down_adv  = dn_ok;
      end
   end

   // one restoring division step per cycle
   always_comb begin
      trial = {rem_ff, quo_ff[SUM_W-1]};
      diff  = trial - {1'b0, div_ff};
      ge    = trial >= {1'b0, div_ff};
   end

   always_comb begin
      state_in = state_ff;
      taken_in = taken_ff;
      vcnt_in  = vcnt_ff;
      sum_in   = sum_ff;
      sweep_in = sweep_ff;
      down_in  = down_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      step_in  = step_ff;
      found_in = found_ff;
      here_in  = here_ff;
      nxt_in   = nxt_ff;
      unique case (state_ff)
         ST_TAKE: begin
            if (!q_empty) begin
               if (last) begin
                  taken_in = '0;
                  vcnt_in  = '0;
                  sum_in   = '0;
                  here_in  = sweep_ff;
                  nxt_in   = sweep_adv;
                  sweep_in = sweep_adv;
                  down_in  = down_adv;
                  quo_in   = sum_next;
                  rem_in   = '0;
                  div_in   = vcnt_next;
                  step_in  = '0;
                  found_in = (vcnt_next != '0);
                  state_in = (vcnt_next != '0) ? ST_DIV : ST_SEND;
               end else begin
                  taken_in = taken_next;
                  vcnt_in  = vcnt_next;
                  sum_in   = sum_next;
               end
            end
         end
         ST_DIV: begin
            rem_in  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_in  = {quo_ff[SUM_W-2:0], ge};
            step_in = step_ff + 1'b1;
            if (step_ff == DSTEP_W'(SUM_W - 1)) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               state_in = ST_TAKE;
            end
         end
         default: begin
            state_in = ST_TAKE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TAKE;
         taken_ff <= '0;
         vcnt_ff  <= '0;
         sum_ff   <= '0;
         sweep_ff <= RST_MIN_ANGLE;
         down_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         taken_ff <= taken_in;
         vcnt_ff  <= vcnt_in;
         sum_ff   <= sum_in;
         sweep_ff <= sweep_in;
         down_ff  <= down_in;
      end
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      step_ff  <= step_in;
      found_ff <= found_in;
      here_ff  <= here_in;
      nxt_ff   <= nxt_in;
   end

`ifndef SYNTHESIS
   a_vcnt_le_taken: assert property (@(posedge clock) disable iff (reset)
      vcnt_ff <= taken_ff)
      else $error("valid reading count exceeds readings taken");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_ff != '0))
      else $error("division started with zero valid readings");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < div_ff))
      else $error("divider remainder out of range");

   a_no_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_TAKE) |-> !q_pop)
      else $error("reading taken from queue while result pending");

   a_send_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(here_ff) && $stable(quo_ff)))
      else $error("pending result lost before it was taken");
`endif

endmodule

// ===== design/ultrasonic_sweep_ranger_core.sv =====
// Sweep ranger top level: each request is one echo width in microseconds (0 means no echo);
// the front end turns it into a Q8 centimetre distance and checks it against the distance
// window, a two-entry queue hands it to the back end, which sums valid distances. After the
// configured number of requests per angle one result gives the scan angle, the truncated mean
// (found=0 and mean 0 when nothing was valid) and the next servo angle of the up/down sweep.
// A request that does not close an angle only updates the running sums in the back end. The
// request that closes an angle runs a restoring division with one step per sum bit
// (17 + log2(MAX_SAMPLES), 20 at the default) when any reading was valid; the result then
// waits in the output register until taken, while the front end and queue still take up to
// three more requests. Configuration registers are written through the csr port, which is
// always ready; indexes past the last register are ignored.
module ultrasonic_sweep_ranger_core import usr_pkg::*; #(
   parameter int MAX_SAMPLES = USR_MAX_SAMPLES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [WIDTH_W-1:0]    req_echo_width_us,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ANGLE_W-1:0]    rsp_scan_angle,
   output logic [DIST_W-1:0]     rsp_mean_distance_q8,
   output logic                  rsp_found,
   output logic [ANGLE_W-1:0]    rsp_next_angle,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   logic        q_push, q_full, q_pop, q_empty;
   reading_type q_data, q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_MIN_ANGLE:    cfg_in.angle_lo        = csr_wdata[ANGLE_W-1:0];
            REG_MAX_ANGLE:    cfg_in.angle_hi        = csr_wdata[ANGLE_W-1:0];
            REG_STEP_ANGLE:   cfg_in.angle_inc       = csr_wdata[ASTEP_W-1:0];
            REG_SAMPLES:      cfg_in.sample_count    = csr_wdata[SPA_REG_W-1:0];
            REG_MIN_DISTANCE: cfg_in.min_distance_q8 = csr_wdata[DIST_W-1:0];
            REG_MAX_DISTANCE: cfg_in.max_distance_q8 = csr_wdata[DIST_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_lo        <= RST_MIN_ANGLE;
         cfg_ff.angle_hi        <= RST_MAX_ANGLE;
         cfg_ff.angle_inc       <= RST_STEP_ANGLE;
         cfg_ff.sample_count    <= RST_SAMPLES;
         cfg_ff.min_distance_q8 <= RST_MIN_DISTANCE;
         cfg_ff.max_distance_q8 <= RST_MAX_DISTANCE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   usr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_echo_width_us (req_echo_width_us),
      .q_push            (q_push),
      .q_data            (q_data),
      .q_full            (q_full)
   );

   usr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   usr_back #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .q_empty              (q_empty),
      .q_head               (q_head),
      .q_pop                (q_pop),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_scan_angle       (rsp_scan_angle),
      .rsp_mean_distance_q8 (rsp_mean_distance_q8),
      .rsp_found            (rsp_found),
      .rsp_next_angle       (rsp_next_angle)
   );

endmodule

// ===== sim/ultrasonic_sweep_ranger_core_test.sv =====
// self-checking testbench for the sweep ranger: directed table, random phases, stalls
module ultrasonic_sweep_ranger_core_test;
   import usr_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES  = 400;
   localparam int PHASES       = 9;
   localparam int PHASE_ITEMS  = 140;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [ANGLE_W-1:0] scan_angle;
      logic [DIST_W-1:0]  mean_q8;
      logic               found;
      logic [ANGLE_W-1:0] next_angle;
   } scan_result_type;

   typedef enum logic [0:0] {ROW_ECHO, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
      logic                  typed;
      scan_result_type       want;
   } stim_row_type;

   localparam scan_result_type NO_RESULT = '0;
   localparam int DIRECTED_ROWS = 49;

   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{ROW_ECHO,  '0,               17'd0,      1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd0,      1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd0,      1'b1, '{8'd15, 17'd0, 1'b0, 8'd17}},
      '{ROW_ECHO,  '0,               17'd65535,  1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd65535,  1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd65535,  1'b1, '{8'd17, 17'd0, 1'b0, 8'd19}},
      // edges of the default distance window
      '{ROW_ECHO,  '0,               17'd117,    1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd116,    1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd23322,  1'b0, NO_RESULT},
      '{ROW_WRITE, REG_SAMPLES,      17'd1,      1'b0, NO_RESULT},
      '{ROW_WRITE, REG_STEP_ANGLE,   17'd90,     1'b0, NO_RESULT},
      '{ROW_WRITE, REG_MAX_ANGLE,    17'd180,    1'b0, NO_RESULT},
      '{ROW_WRITE, REG_MIN_ANGLE,    17'd0,      1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd40000,  1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd1,      1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd20000,  1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd300,    1'b0, NO_RESULT},
      // zero samples and zero step
      '{ROW_WRITE, REG_SAMPLES,      17'd0,      1'b0, NO_RESULT},
      '{ROW_WRITE, REG_STEP_ANGLE,   17'd0,      1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd5000,   1'b0, NO_RESULT},
      // sample count above the cap, widest window
      '{ROW_WRITE, REG_SAMPLES,      17'd15,     1'b0, NO_RESULT},
      '{ROW_WRITE, REG_MIN_DISTANCE, 17'd0,      1'b0, NO_RESULT},
      '{ROW_WRITE, REG_MAX_DISTANCE, 17'd131071, 1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd0,      1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd1,      1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd29852,  1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd29853,  1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd65535,  1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd32768,  1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd21845,  1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd43690,  1'b0, NO_RESULT},
      // inverted distance window
      '{ROW_WRITE, REG_MIN_DISTANCE, 17'd131071, 1'b0, NO_RESULT},
      '{ROW_WRITE, REG_MAX_DISTANCE, 17'd0,      1'b0, NO_RESULT},
      '{ROW_WRITE, REG_SAMPLES,      17'd1,      1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd30000,  1'b0, NO_RESULT},
      // inverted angle limits, upper data bits masked off, spare indexes ignored
      '{ROW_WRITE, REG_MIN_ANGLE,    17'h1FFAA,  1'b0, NO_RESULT},
      '{ROW_WRITE, REG_MAX_ANGLE,    17'h10014,  1'b0, NO_RESULT},
      '{ROW_WRITE, REG_STEP_ANGLE,   17'h1FF85,  1'b0, NO_RESULT},
      '{ROW_WRITE, REG_SPARE_LO,     17'h1FFFF,  1'b0, NO_RESULT},
      '{ROW_WRITE, REG_SPARE_HI,     17'h00000,  1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd10000,  1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd10000,  1'b0, NO_RESULT},
      // sample count lowered partway through an angle
      '{ROW_WRITE, REG_MIN_DISTANCE, 17'd512,    1'b0, NO_RESULT},
      '{ROW_WRITE, REG_MAX_DISTANCE, 17'd102400, 1'b0, NO_RESULT},
      '{ROW_WRITE, REG_SAMPLES,      17'd4,      1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd15000,  1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd2000,   1'b0, NO_RESULT},
      '{ROW_WRITE, REG_SAMPLES,      17'd1,      1'b0, NO_RESULT},
      '{ROW_ECHO,  '0,               17'd0,      1'b0, NO_RESULT}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [WIDTH_W-1:0]    req_echo_width_us = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [ANGLE_W-1:0]    rsp_scan_angle;
   logic [DIST_W-1:0]     rsp_mean_distance_q8;
   logic                  rsp_found;
   logic [ANGLE_W-1:0]    rsp_next_angle;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   ultrasonic_sweep_ranger_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_echo_width_us    (req_echo_width_us),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_scan_angle       (rsp_scan_angle),
      .rsp_mean_distance_q8 (rsp_mean_distance_q8),
      .rsp_found            (rsp_found),
      .rsp_next_angle       (rsp_next_angle),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // sweep predictor state and register copy
   cfg_type            ranger_cfg;
   logic [ANGLE_W-1:0] aim_angle;
   bit                 heading_down;
   int                 echo_count;
   int                 hit_count;
   int unsigned        hit_sum;

   scan_result_type scan_q[$];
   int  fail_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 37;
   int  rsp_stall_pct = 61;
   bit  hold_request = 1'b0;

   function automatic bit range_echo(input logic [WIDTH_W-1:0] w, output scan_result_type r);
      int unsigned dist_q8;
      int          needed;
      int          up;
      r = '0;
      dist_q8 = (int'(w) * int'(DIST_MUL)) >> DIST_SHIFT;
      if (w != 0 && dist_q8 >= ranger_cfg.min_distance_q8
          && dist_q8 <= ranger_cfg.max_distance_q8) begin
         hit_sum += dist_q8;
         hit_count++;
      end
      echo_count++;
      needed = ranger_cfg.sample_count;
      if (needed == 0)
         needed = 1;
      if (needed > USR_MAX_SAMPLES)
         needed = USR_MAX_SAMPLES;
      if (echo_count < needed)
         return 1'b0;
      r.scan_angle = aim_angle;
      r.found = (hit_count != 0);
      r.mean_q8 = (hit_count != 0) ? DIST_W'(hit_sum / hit_count) : '0;
      if (!heading_down) begin
         up = int'(aim_angle) + int'(ranger_cfg.angle_inc);
         if (up <= int'(ranger_cfg.angle_hi)) begin
            aim_angle = ANGLE_W'(up);
         end else begin
            aim_angle = ranger_cfg.angle_hi;
            heading_down = 1'b1;
         end
      end else if (int'(aim_angle) >= int'(ranger_cfg.angle_lo) + int'(ranger_cfg.angle_inc)) begin
         aim_angle = aim_angle - ANGLE_W'(ranger_cfg.angle_inc);
      end else begin
         aim_angle = ranger_cfg.angle_lo;
         heading_down = 1'b0;
      end
      r.next_angle = aim_angle;
      echo_count = 0;
      hit_count = 0;
      hit_sum = 0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   // csr_valid is left high so back-to-back writes need no drop in between
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!(csr_valid && csr_ready))
         @(posedge clock);
      case (idx)
         REG_MIN_ANGLE:    ranger_cfg.angle_lo = val[ANGLE_W-1:0];
         REG_MAX_ANGLE:    ranger_cfg.angle_hi = val[ANGLE_W-1:0];
         REG_STEP_ANGLE:   ranger_cfg.angle_inc = val[ASTEP_W-1:0];
         REG_SAMPLES:      ranger_cfg.sample_count = val[SPA_REG_W-1:0];
         REG_MIN_DISTANCE: ranger_cfg.min_distance_q8 = val[DIST_W-1:0];
         REG_MAX_DISTANCE: ranger_cfg.max_distance_q8 = val[DIST_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_echo(input logic [WIDTH_W-1:0] w, input bit typed,
                            input scan_result_type want);
      scan_result_type predicted;
      csr_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_echo_width_us <= w;
      @(posedge clock);
      while (!(req_valid && !req_stall))
         @(posedge clock);
      if (range_echo(w, predicted))
         scan_q.push_back(typed ? want : predicted);
   endtask

   // requests that close no angle leave no trace, so give the pipe time to settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (scan_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // receiver side: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      scan_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (scan_q.size() == 0) begin
            report_mismatch($sformatf("result angle %0d with nothing expected", rsp_scan_angle));
         end else begin
            want = scan_q.pop_front();
            if (rsp_scan_angle !== want.scan_angle)
               report_mismatch($sformatf("scan_angle %0d, expected %0d",
                                         rsp_scan_angle, want.scan_angle));
            if (rsp_mean_distance_q8 !== want.mean_q8)
               report_mismatch($sformatf("mean_distance_q8 %0d, expected %0d",
                                         rsp_mean_distance_q8, want.mean_q8));
            if (rsp_found !== want.found)
               report_mismatch($sformatf("found %0d, expected %0d", rsp_found, want.found));
            if (rsp_next_angle !== want.next_angle)
               report_mismatch($sformatf("next_angle %0d, expected %0d",
                                         rsp_next_angle, want.next_angle));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ultrasonic_sweep_ranger_core_test: errors");
         $finish;
      end
   end

   initial begin
      int unsigned min_a;
      int unsigned max_a;
      int unsigned step_a;
      int unsigned samples;
      int unsigned min_d;
      int unsigned max_d;
      int          width_cap;
      logic [WIDTH_W-1:0] w;

      ranger_cfg.angle_lo = RST_MIN_ANGLE;
      ranger_cfg.angle_hi = RST_MAX_ANGLE;
      ranger_cfg.angle_inc = RST_STEP_ANGLE;
      ranger_cfg.sample_count = RST_SAMPLES;
      ranger_cfg.min_distance_q8 = RST_MIN_DISTANCE;
      ranger_cfg.max_distance_q8 = RST_MAX_DISTANCE;
      aim_angle = RST_MIN_ANGLE;
      heading_down = 1'b0;
      echo_count = 0;
      hit_count = 0;
      hit_sum = 0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (DIRECTED[i].kind == ROW_WRITE) begin
            if (i > 0 && DIRECTED[i-1].kind == ROW_ECHO)
               wait_idle();
            write_reg(DIRECTED[i].index, DIRECTED[i].data);
         end else begin
            send_echo(DIRECTED[i].data[WIDTH_W-1:0], DIRECTED[i].typed, DIRECTED[i].want);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase / 3)
            0: begin
               send_idle_pct = 37;
               rsp_stall_pct = 61;
            end
            1: begin
               send_idle_pct = 61;
               rsp_stall_pct = 37;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         wait_idle();

         case ($urandom_range(5))
            0: min_a = 0;
            1: min_a = 180;
            2: min_a = $urandom_range(255);
            default: min_a = $urandom_range(60);
         endcase
         case ($urandom_range(5))
            0: max_a = 180;
            1: max_a = 0;
            2: max_a = $urandom_range(255);
            default: max_a = $urandom_range(180, 100);
         endcase
         case ($urandom_range(7))
            0: step_a = 90;
            1: step_a = 127;
            2: step_a = 0;
            default: step_a = $urandom_range(20, 1);
         endcase
         if ($urandom_range(3) == 0)
            samples = $urandom_range(15);
         else
            samples = $urandom_range(8, 1);
         case ($urandom_range(5))
            0: min_d = 0;
            1: min_d = $urandom_range(131071);
            default: min_d = $urandom_range(4000);
         endcase
         case ($urandom_range(5))
            0: max_d = 131071;
            1: max_d = $urandom_range(131071);
            default: max_d = $urandom_range(131071, 20000);
         endcase

         write_reg(REG_MIN_ANGLE, CSR_DATA_W'(min_a));
         write_reg(REG_MAX_ANGLE, CSR_DATA_W'(max_a));
         write_reg(REG_STEP_ANGLE, CSR_DATA_W'(step_a));
         write_reg(REG_SAMPLES, CSR_DATA_W'(samples));
         write_reg(REG_MIN_DISTANCE, CSR_DATA_W'(min_d));
         write_reg(REG_MAX_DISTANCE, CSR_DATA_W'(max_d));
         if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI,
                      CSR_DATA_W'($urandom_range(131071)));

         // widths up to one step past the top of the window
         width_cap = (int'(max_d) * 1024) / int'(DIST_MUL) + 1;
         if (width_cap > 65535)
            width_cap = 65535;

         // long receiver hold-off while the sender keeps pushing
         if (phase == PHASES - 2)
            hold_request = 1'b1;

         repeat (PHASE_ITEMS) begin
            case ($urandom_range(19))
               0, 1, 2:    w = '0;
               3, 4, 5, 6: w = WIDTH_W'($urandom_range(65535));
               default:    w = WIDTH_W'($urandom_range(width_cap, 1));
            endcase
            send_echo(w, 1'b0, NO_RESULT);
         end
      end

      wait_idle();
      if (fail_count == 0)
         $display("ultrasonic_sweep_ranger_core_test: clean");
      else
         $display("ultrasonic_sweep_ranger_core_test: errors");
      $finish;
   end

endmodule
